@@ rtl/double_ended_queue_top_macros.svh @@
// Assertion macros for the double-ended queue.
// Used by double_ended_queue_top.sv; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define DQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is held.
`define DQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
// No dependencies; used by every module of the block.
package dq_pkg;

  // Word width and default capacity.
  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 16;
  localparam int COUNT_W   = 5;

  // Action codes carried on in_action.
  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_BACK   = 2'd2,
    ACT_POP_FRONT  = 2'd3
  } action_t;

  // Status codes returned on out_status.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctrl_t;

  // Fill state reported by the chain.
  typedef struct packed {
    logic empty;
    logic full;
  } chain_stat_t;

endpackage

@@ rtl/dq_cell.sv @@
// One storage cell of the deque chain: an occupancy flag and one word.
// Depends on dq_pkg.
module dq_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dq_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [dq_pkg::DATA_W-1:0]   new_word,
  input  logic                               left_occ,
  input  logic signed [dq_pkg::DATA_W-1:0]   left_word,
  input  logic                               right_occ,
  input  logic signed [dq_pkg::DATA_W-1:0]   right_word,
  output logic                               occ,
  output logic signed [dq_pkg::DATA_W-1:0]   word,
  output logic                               is_last
);

  logic                             occ_r;
  logic                             occ_nxt;
  logic signed [dq_pkg::DATA_W-1:0] word_r;
  logic signed [dq_pkg::DATA_W-1:0] word_nxt;

  // A front push shifts toward the back, a front pop shifts toward the front.
  // Back operations touch only the cell at the boundary of the filled run.
  always_comb begin
    occ_nxt  = occ_r;
    word_nxt = word_r;
    if (ctrl.push_front) begin
      occ_nxt  = left_occ;
      word_nxt = left_word;
    end else if (ctrl.pop_front) begin
      occ_nxt  = right_occ;
      word_nxt = right_word;
    end else if (ctrl.push_back && !occ_r && left_occ) begin
      occ_nxt  = 1'b1;
      word_nxt = new_word;
    end else if (ctrl.pop_back && occ_r && !right_occ) begin
      occ_nxt  = 1'b0;
    end
  end

  // Occupancy is control state and is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // The word itself needs no reset.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign occ     = occ_r;
  assign word    = word_r;
  assign is_last = occ_r & ~right_occ;

endmodule

@@ rtl/dq_chain.sv @@
// Row of deque cells with the front word at cell zero, plus back-word select.
// Depends on dq_pkg and dq_cell.
module dq_chain #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dq_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [dq_pkg::DATA_W-1:0]   new_word,
  output logic signed [dq_pkg::DATA_W-1:0]   front_word,
  output logic signed [dq_pkg::DATA_W-1:0]   back_word,
  output dq_pkg::chain_stat_t                stat
);

  logic                             occ_w  [DEPTH];
  logic signed [dq_pkg::DATA_W-1:0] word_w [DEPTH];
  logic                             last_w [DEPTH];

  // Each cell sees its two neighbors; the ends see a filled slot holding the
  // new word at the front and an empty slot at the back.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             l_occ;
    logic signed [dq_pkg::DATA_W-1:0] l_word;
    logic                             r_occ;
    logic signed [dq_pkg::DATA_W-1:0] r_word;

    if (i == 0) begin : g_head
      assign l_occ  = 1'b1;
      assign l_word = new_word;
    end else begin : g_mid_l
      assign l_occ  = occ_w[i-1];
      assign l_word = word_w[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign r_occ  = 1'b0;
      assign r_word = '0;
    end else begin : g_mid_r
      assign r_occ  = occ_w[i+1];
      assign r_word = word_w[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_word   (new_word),
      .left_occ   (l_occ),
      .left_word  (l_word),
      .right_occ  (r_occ),
      .right_word (r_word),
      .occ        (occ_w[i]),
      .word       (word_w[i]),
      .is_last    (last_w[i])
    );
  end

  // Exactly one cell flags itself as last when the queue holds anything,
  // so a one-hot AND-OR picks the back word.
  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | (word_w[i] & {dq_pkg::DATA_W{last_w[i]}});
    end
  end

  assign front_word = word_w[0];
  assign stat.empty = ~occ_w[0];
  assign stat.full  = occ_w[DEPTH-1];

endmodule

@@ rtl/double_ended_queue_top.sv @@
// Bounded double-ended queue of signed 32-bit words, built as a chain of cells.
// Depends on dq_pkg, dq_chain and double_ended_queue_top_macros.svh.
//
// One action is taken in every clock cycle: busy never rises, so start may be
// held high continuously. Each accepted action yields exactly one result,
// shown for one cycle with out_valid high in the cycle after acceptance; the
// receiver cannot stall it and must take it then. The cell chain updates its
// stored words in the same edge that updates the count; a front action shifts
// every stored word. Storage needs no clearing after reset.
`include "double_ended_queue_top_macros.svh"
module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_action,
  input  logic signed [dq_pkg::DATA_W-1:0]   in_value,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic signed [dq_pkg::DATA_W-1:0]   out_removed_value,
  output logic [dq_pkg::COUNT_W-1:0]         out_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W > dq_pkg::COUNT_W) ? CNT_W : dq_pkg::COUNT_W;

  logic                             accept;
  logic                             push_refused;
  dq_pkg::action_t                  act;
  dq_pkg::cell_ctrl_t               ctrl;
  dq_pkg::chain_stat_t              stat;
  logic signed [dq_pkg::DATA_W-1:0] front_word;
  logic signed [dq_pkg::DATA_W-1:0] back_word;

  logic [CNT_W-1:0]                 count_r;
  logic [CNT_W-1:0]                 count_nxt;
  logic [EXT_W-1:0]                 count_ext;
  logic                             valid_r;
  dq_pkg::status_t                  status_r;
  dq_pkg::status_t                  status_nxt;
  logic signed [dq_pkg::DATA_W-1:0] removed_r;
  logic signed [dq_pkg::DATA_W-1:0] removed_nxt;
  logic [dq_pkg::COUNT_W-1:0]       ocount_r;
  logic [dq_pkg::COUNT_W-1:0]       ocount_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign act    = dq_pkg::action_t'(in_action);

  // Decode the action into chain commands, refusing pushes when full and
  // pops when empty.
  always_comb begin
    ctrl        = '0;
    status_nxt  = dq_pkg::ST_DONE;
    removed_nxt = '0;
    count_nxt   = count_r;
    unique case (act) inside
      dq_pkg::ACT_PUSH_BACK, dq_pkg::ACT_PUSH_FRONT: begin
        if (stat.full) begin
          status_nxt = dq_pkg::ST_FULL;
        end else begin
          ctrl.push_back  = accept & (act == dq_pkg::ACT_PUSH_BACK);
          ctrl.push_front = accept & (act == dq_pkg::ACT_PUSH_FRONT);
          count_nxt       = count_r + CNT_W'(1);
        end
      end
      dq_pkg::ACT_POP_BACK, dq_pkg::ACT_POP_FRONT: begin
        if (stat.empty) begin
          status_nxt = dq_pkg::ST_EMPTY;
        end else begin
          ctrl.pop_back  = accept & (act == dq_pkg::ACT_POP_BACK);
          ctrl.pop_front = accept & (act == dq_pkg::ACT_POP_FRONT);
          removed_nxt    = (act == dq_pkg::ACT_POP_BACK) ? back_word : front_word;
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = dq_pkg::ST_DONE;
      end
    endcase
  end

  // The reported count carries the low bits of the count after the action.
  assign count_ext  = EXT_W'(count_nxt);
  assign ocount_nxt = count_ext[dq_pkg::COUNT_W-1:0];

  dq_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .new_word   (in_value),
    .front_word (front_word),
    .back_word  (back_word),
    .stat       (stat)
  );

  // Held count and the result strobe are control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      ocount_r  <= ocount_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_count         = ocount_r;

  // An accepted push that meets a full queue.
  assign push_refused = accept & stat.full &
                        ((act == dq_pkg::ACT_PUSH_BACK) | (act == dq_pkg::ACT_PUSH_FRONT));

  // The held count never passes the capacity.
  `DQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  // The chain reports empty exactly when the held count is zero.
  `DQ_ASSERT_IMP(a_empty_match, clk, rst_n, 1'b1, stat.empty == (count_r == '0))
  // Every accepted action yields a result in the next cycle.
  `DQ_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, out_valid)
  // A push on a full queue is reported as refused.
  `DQ_ASSERT_NEXT(a_full_flag, clk, rst_n, push_refused, out_status == dq_pkg::ST_FULL)

endmodule
